// ----- src/scfre_pkg.sv -----
// shared types, constants and crc-8 functions for the spi register frame engine
// no dependencies; used by every module of the engine
`default_nettype none

package scfre_pkg;

    localparam logic [7:0] RW_FLAG      = 8'h80;
    localparam logic [7:0] CRC_POLY     = 8'h07;
    localparam logic [7:0] READ_FILLER  = 8'hFF;
    localparam logic [3:0] RESENDS_INIT = 4'd10;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_REPLY = 1'b1;

    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 40;

    localparam logic REG_MAX_RESENDS = 1'b0;

    typedef struct packed {
        logic       req_type;
        logic       is_write;
        logic [6:0] reg_address;
        logic [7:0] write_data;
        logic [7:0] reply_byte0;
        logic [7:0] reply_byte1;
        logic [7:0] reply_byte2;
    } item_t;

    typedef struct packed {
        logic        busy;
        logic        pending_write;
        logic [23:0] pending_frame;
        logic [3:0]  resend_count;
    } state_t;

    typedef struct packed {
        logic       send_frame;
        logic [7:0] frame_addr_byte;
        logic [7:0] frame_data_byte;
        logic [7:0] frame_crc_byte;
        logic       access_done;
        logic       access_failed;
        logic [7:0] read_value;
    } result_t;

    // msb first, no reflection, no final xor
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] frame_crc(input logic [7:0] a, input logic [7:0] d);
        return crc8_byte(crc8_byte(8'h00, a), d);
    endfunction

endpackage

`default_nettype wire

// ----- src/scfre_step.sv -----
// next-state and result logic for one word of the frame engine
// depends on scfre_pkg
`default_nettype none

module scfre_step
(
    input  wire scfre_pkg::item_t  item,
    input  wire scfre_pkg::state_t state,
    input  wire [3:0]              max_resends,
    output scfre_pkg::state_t      state_next,
    output scfre_pkg::result_t     result
);

    logic [7:0]  new_addr;
    logic [7:0]  new_data;
    logic [23:0] new_frame;
    logic [7:0]  pend_addr;
    logic [7:0]  pend_data;
    logic [7:0]  pend_crc;
    logic        reply_ok;

    assign new_addr  = {item.is_write, item.reg_address};
    assign new_data  = item.is_write ? item.write_data : scfre_pkg::READ_FILLER;
    assign new_frame = {new_addr, new_data, scfre_pkg::frame_crc(new_addr, new_data)};

    assign pend_addr = state.pending_frame[23:16];
    assign pend_data = state.pending_frame[15:8];
    assign pend_crc  = state.pending_frame[7:0];

    // writes need the whole frame echoed, reads only the address byte
    assign reply_ok = state.pending_write
                    ? ((item.reply_byte0 == pend_addr) && (item.reply_byte1 == pend_data)
                       && (item.reply_byte2 == pend_crc))
                    : (item.reply_byte0 == pend_addr);

    always_comb
    begin
        state_next = state;
        result     = '0;
        case (item.req_type)
            scfre_pkg::REQ_START:
            begin
                state_next.busy          = 1'b1;
                state_next.pending_write = item.is_write;
                state_next.pending_frame = new_frame;
                state_next.resend_count  = 4'd0;
                result.send_frame        = 1'b1;
                result.frame_addr_byte   = new_frame[23:16];
                result.frame_data_byte   = new_frame[15:8];
                result.frame_crc_byte    = new_frame[7:0];
            end
            scfre_pkg::REQ_REPLY:
            begin
                if (state.busy)
                begin
                    if (reply_ok)
                    begin
                        result.access_done = 1'b1;
                        result.read_value  = state.pending_write ? 8'h00 : item.reply_byte1;
                        state_next.busy    = 1'b0;
                    end
                    else if (state.resend_count < max_resends)
                    begin
                        state_next.resend_count = state.resend_count + 4'd1;
                        result.send_frame       = 1'b1;
                        result.frame_addr_byte  = pend_addr;
                        result.frame_data_byte  = pend_data;
                        result.frame_crc_byte   = pend_crc;
                    end
                    else
                    begin
                        result.access_failed = 1'b1;
                        state_next.busy      = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/spi_crc_frame_retry_engine_unit.sv -----
// top level of the spi register frame engine: stream ports, apb register, state
// depends on scfre_pkg and scfre_step
// a result word is registered and appears in the cycle after its input word is accepted
// throughput: one input word per cycle while the result side keeps up
// the result register frees in the same cycle it is taken downstream
// reset (rst_n low, async) clears the access state and the result valid
// max_resends returns to 10 on reset
`default_nettype none

module spi_crc_frame_retry_engine_unit
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    // is_write[0], reg_address[7:1], write_data[15:8], reply_byte0[23:16],
    // reply_byte1[31:24], reply_byte2[39:32]
    input  wire [39:0]  s_tdata,
    // req_type[0]
    input  wire [0:0]   s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // send_frame[0], frame_addr_byte[8:1], frame_data_byte[16:9],
    // frame_crc_byte[24:17], access_done[25], access_failed[26],
    // read_value[34:27], zero[39:35]
    output logic [39:0] m_tdata,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [2:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    scfre_pkg::item_t   item;
    scfre_pkg::state_t  state_reg;
    scfre_pkg::state_t  state_next;
    scfre_pkg::result_t result;
    logic [3:0]         max_resends_reg;
    logic               m_valid_reg;
    logic [39:0]        m_data_reg;
    logic               in_accept;
    logic               cfg_write;

    assign item.req_type    = s_tuser[0];
    assign item.is_write    = s_tdata[0];
    assign item.reg_address = s_tdata[7:1];
    assign item.write_data  = s_tdata[15:8];
    assign item.reply_byte0 = s_tdata[23:16];
    assign item.reply_byte1 = s_tdata[31:24];
    assign item.reply_byte2 = s_tdata[39:32];

    assign s_tready  = !m_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == scfre_pkg::REG_MAX_RESENDS);
    assign prdata    = (paddr[2] == scfre_pkg::REG_MAX_RESENDS) ? {28'd0, max_resends_reg}
                                                                 : 32'd0;

    scfre_step u_step
    (
        .item        (item),
        .state       (state_reg),
        .max_resends (max_resends_reg),
        .state_next  (state_next),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= '0;
            max_resends_reg <= scfre_pkg::RESENDS_INIT;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                state_reg <= state_next;
            end
            if (cfg_write)
            begin
                max_resends_reg <= pwdata[3:0];
            end
            if (in_accept)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            m_data_reg <= {5'd0, result.read_value, result.access_failed, result.access_done,
                           result.frame_crc_byte, result.frame_data_byte,
                           result.frame_addr_byte, result.send_frame};
        end
    end

endmodule

`default_nettype wire

// ----- src/scfre_checker.sv -----
// port-level assertions for the spi register frame engine, bound to the top level
// depends on scfre_pkg and spi_crc_frame_retry_engine_unit
`default_nettype none

module scfre_checker
(
    input wire        clk,
    input wire        rst_n,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [39:0] m_tdata
);

    // stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // every accepted word yields a result word next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted word produced no result");

    // at most one of send, done, failed
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !((m_tdata[0] && (m_tdata[25] || m_tdata[26]))
                       || (m_tdata[25] && m_tdata[26])))
        else $error("conflicting result flags");

    // read data only accompanies a completed access
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[34:27] != 8'd0) |-> m_tdata[25])
        else $error("read value without access done");

    // a sent frame carries a consistent crc
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[24:17] == scfre_pkg::frame_crc(m_tdata[8:1],
                                                                           m_tdata[16:9]))
        else $error("frame crc mismatch");

endmodule

bind spi_crc_frame_retry_engine_unit scfre_checker u_scfre_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- test/spi_crc_frame_retry_engine_unit_test.sv -----
// self-checking testbench for the spi register frame engine: directed table, then random accesses
// checks every result word against an in-bench predictor of frame crc, echo check and resends,
// or a typed table row's result; depends on scfre_pkg and spi_crc_frame_retry_engine_unit
`timescale 1ns / 100ps

module spi_crc_frame_retry_engine_unit_test;

    localparam int PERIOD        = 4;
    localparam int HOLD_CYCLES   = 64;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 10;
    localparam int PHASE_WORDS   = 345;
    localparam logic [2:0] MAX_RESENDS_ADDR = {scfre_pkg::REG_MAX_RESENDS, 2'b00};

    localparam scfre_pkg::result_t NO_RESULT = '0;
    localparam scfre_pkg::result_t FAIL_ONLY = '{access_failed: 1'b1, default: '0};

    typedef enum logic [1:0] {ROW_START, ROW_REPLY, ROW_ECHO, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic               wr;
        logic [6:0]         addr;
        logic [7:0]         wd;
        logic [23:0]        bytes;
        logic               typed;
        scfre_pkg::result_t want;
    } row_t;

    // bytes: reply bytes for starts and replies, xor mask on the pending frame for echoes
    row_t plan [0:24] = '{
        '{ROW_REPLY, 1'b1, 7'h7F, 8'hFF, 24'hFFFFFF, 1'b1, NO_RESULT},
        '{ROW_START, 1'b1, 7'h7F, 8'hFF, 24'hFFFFFF, 1'b0, NO_RESULT},
        '{ROW_ECHO,  1'b0, 7'h00, 8'h00, 24'h000000, 1'b0, NO_RESULT},
        '{ROW_START, 1'b0, 7'h00, 8'hAA, 24'h000000, 1'b0, NO_RESULT},
        '{ROW_ECHO,  1'b1, 7'h7F, 8'hFF, 24'h00FFFF, 1'b0, NO_RESULT},
        '{ROW_START, 1'b1, 7'h55, 8'h00, 24'h123456, 1'b0, NO_RESULT},
        '{ROW_ECHO,  1'b0, 7'h00, 8'h00, 24'h000001, 1'b0, NO_RESULT},
        '{ROW_ECHO,  1'b0, 7'h00, 8'h00, 24'h000100, 1'b0, NO_RESULT},
        '{ROW_ECHO,  1'b0, 7'h00, 8'h00, 24'h800000, 1'b0, NO_RESULT},
        '{ROW_ECHO,  1'b0, 7'h00, 8'h00, 24'h000000, 1'b0, NO_RESULT},
        '{ROW_START, 1'b0, 7'h2A, 8'h00, 24'h000000, 1'b0, NO_RESULT},
        '{ROW_START, 1'b1, 7'h13, 8'h5A, 24'h000000, 1'b0, NO_RESULT},
        '{ROW_ECHO,  1'b0, 7'h00, 8'h00, 24'h000000, 1'b0, NO_RESULT},
        '{ROW_CFG,   1'b0, 7'h00, 8'h00, 24'h000000, 1'b0, NO_RESULT},
        '{ROW_START, 1'b0, 7'h7F, 8'h00, 24'h000000, 1'b0, NO_RESULT},
        '{ROW_ECHO,  1'b0, 7'h00, 8'h00, 24'h010000, 1'b1, FAIL_ONLY},
        '{ROW_REPLY, 1'b0, 7'h00, 8'h00, 24'h000000, 1'b1, NO_RESULT},
        '{ROW_CFG,   1'b0, 7'h00, 8'h01, 24'h000000, 1'b0, NO_RESULT},
        '{ROW_START, 1'b1, 7'h00, 8'h80, 24'h000000, 1'b0, NO_RESULT},
        '{ROW_ECHO,  1'b0, 7'h00, 8'h00, 24'h000080, 1'b0, NO_RESULT},
        '{ROW_ECHO,  1'b0, 7'h00, 8'h00, 24'h000080, 1'b1, FAIL_ONLY},
        '{ROW_START, 1'b0, 7'h40, 8'hFF, 24'h000000, 1'b0, NO_RESULT},
        '{ROW_ECHO,  1'b0, 7'h00, 8'h00, 24'hFF0000, 1'b0, NO_RESULT},
        '{ROW_ECHO,  1'b0, 7'h00, 8'h00, 24'h000000, 1'b0, NO_RESULT},
        '{ROW_CFG,   1'b0, 7'h00, 8'h0F, 24'h000000, 1'b0, NO_RESULT}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // predictor copy of the engine
    logic        eng_busy = 1'b0;
    logic        eng_write = 1'b0;
    logic [23:0] eng_frame = '0;
    logic [3:0]  eng_resends = '0;
    logic [3:0]  cfg_max_resends = scfre_pkg::RESENDS_INIT;

    scfre_pkg::result_t expected_results [$];
    int      words_sent = 0;
    int      errors = 0;
    int      idle_cycles = 0;
    logic    quiet = 1'b0;
    logic    long_hold = 1'b0;

    spi_crc_frame_retry_engine_unit DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(PERIOD / 2) clk = ~clk;

    // bit-serial crc over address byte then data byte
    function automatic logic [7:0] crc8_serial(input logic [15:0] msg);
        logic [7:0] c;
        logic       fb;
        c = 8'h00;
        for (int i = 15; i >= 0; i--)
        begin
            fb = c[7] ^ msg[i];
            c = {c[6:0], 1'b0};
            if (fb)
                c = c ^ scfre_pkg::CRC_POLY;
        end
        return c;
    endfunction

    function automatic scfre_pkg::result_t engine_step(input scfre_pkg::item_t it);
        scfre_pkg::result_t r;
        logic [7:0] a;
        logic [7:0] d;
        logic       ok;
        r = '0;
        words_sent++;
        if (it.req_type == scfre_pkg::REQ_START)
        begin
            a = {1'b0, it.reg_address} | (it.is_write ? scfre_pkg::RW_FLAG : 8'h00);
            d = it.is_write ? it.write_data : scfre_pkg::READ_FILLER;
            eng_frame = {a, d, crc8_serial({a, d})};
            eng_write = it.is_write;
            eng_resends = '0;
            eng_busy = 1'b1;
            {r.frame_addr_byte, r.frame_data_byte, r.frame_crc_byte} = eng_frame;
            r.send_frame = 1'b1;
        end
        else if (eng_busy)
        begin
            if (eng_write)
                ok = {it.reply_byte0, it.reply_byte1, it.reply_byte2} == eng_frame;
            else
                ok = it.reply_byte0 == eng_frame[23:16];
            if (ok)
            begin
                r.access_done = 1'b1;
                r.read_value = eng_write ? 8'h00 : it.reply_byte1;
                eng_busy = 1'b0;
            end
            else if (eng_resends < cfg_max_resends)
            begin
                eng_resends = eng_resends + 4'd1;
                {r.frame_addr_byte, r.frame_data_byte, r.frame_crc_byte} = eng_frame;
                r.send_frame = 1'b1;
            end
            else
            begin
                r.access_failed = 1'b1;
                eng_busy = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic scfre_pkg::item_t random_item(input logic req);
        scfre_pkg::item_t it;
        it.req_type = req;
        it.is_write = 1'($urandom_range(0, 1));
        it.reg_address = 7'($urandom_range(0, 127));
        it.write_data = 8'($urandom_range(0, 255));
        it.reply_byte0 = 8'($urandom_range(0, 255));
        it.reply_byte1 = 8'($urandom_range(0, 255));
        it.reply_byte2 = 8'($urandom_range(0, 255));
        return it;
    endfunction

    task automatic report_fault(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_fault($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task automatic send_word(input scfre_pkg::item_t it, input logic typed,
                             input scfre_pkg::result_t want);
        scfre_pkg::result_t p;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.req_type;
        s_tdata <= {it.reply_byte2, it.reply_byte1, it.reply_byte0, it.write_data,
                    it.reg_address, it.is_write};
        do
            @(posedge clk);
        while (!s_tready);
        p = engine_step(it);
        expected_results.push_back(typed ? want : p);
    endtask

    task automatic drain_results;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_max_resends(input logic [3:0] value);
        drain_results();
        repeat (2) @(posedge clk);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= MAX_RESENDS_ADDR;
        pwdata <= {28'h0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        cfg_max_resends = value;
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (pready !== 1'b1 || prdata !== {28'h0, value})
            report_fault($sformatf("max_resends read %0h want %0h", prdata, value));
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_random(input logic [3:0] setting, input int n, input logic last,
                              input logic hold, input logic pause);
        int    goal;
        int    pick;
        int    ok_pct;
        logic  paused;
        scfre_pkg::item_t it;
        write_max_resends(setting);
        long_hold = hold;
        goal = words_sent + n;
        paused = 1'b0;
        ok_pct = setting >= 4'd8 ? 6 : 35;
        while (words_sent < goal)
        begin
            quiet = last && (goal - words_sent < 150);
            if (pause && !paused && goal - words_sent < n / 2)
            begin
                paused = 1'b1;
                drain_results();
            end
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                send_word(random_item(scfre_pkg::REQ_START), 1'b0, NO_RESULT);
                for (int k = 0; k < 24 && eng_busy && words_sent < goal; k++)
                begin
                    it = random_item(scfre_pkg::REQ_REPLY);
                    pick = $urandom_range(0, 99);
                    if (pick < ok_pct)
                    begin
                        if (eng_write)
                            {it.reply_byte0, it.reply_byte1, it.reply_byte2} = eng_frame;
                        else
                            it.reply_byte0 = eng_frame[23:16];
                    end
                    else if (pick < 92)
                        {it.reply_byte0, it.reply_byte1, it.reply_byte2} =
                            eng_frame ^ 24'($urandom_range(1, 24'hFFFFFF));
                    else if (pick < 96)
                        it = random_item(scfre_pkg::REQ_START);
                    send_word(it, 1'b0, NO_RESULT);
                end
            end
            else if (pick < 90)
                send_word(random_item(scfre_pkg::REQ_REPLY), 1'b0, NO_RESULT);
            else
            begin
                send_word(random_item(scfre_pkg::REQ_START), 1'b0, NO_RESULT);
                send_word(random_item(scfre_pkg::REQ_START), 1'b0, NO_RESULT);
            end
        end
    endtask

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                long_hold = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7) - 1) @(negedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        scfre_pkg::result_t got;
        scfre_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.send_frame = m_tdata[0];
            got.frame_addr_byte = m_tdata[8:1];
            got.frame_data_byte = m_tdata[16:9];
            got.frame_crc_byte = m_tdata[24:17];
            got.access_done = m_tdata[25];
            got.access_failed = m_tdata[26];
            got.read_value = m_tdata[34:27];
            if (expected_results.size() == 0)
                report_fault($sformatf("unexpected word %0h", m_tdata));
            else
            begin
                want = expected_results.pop_front();
                check_field("send_frame", 8'(got.send_frame), 8'(want.send_frame));
                check_field("frame_addr_byte", got.frame_addr_byte, want.frame_addr_byte);
                check_field("frame_data_byte", got.frame_data_byte, want.frame_data_byte);
                check_field("frame_crc_byte", got.frame_crc_byte, want.frame_crc_byte);
                check_field("access_done", 8'(got.access_done), 8'(want.access_done));
                check_field("access_failed", 8'(got.access_failed), 8'(want.access_failed));
                check_field("read_value", got.read_value, want.read_value);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT)
        begin
            $display("** spi_crc_frame_retry_engine_unit: FAILED **");
            $finish;
        end
    end

    initial
    begin
        scfre_pkg::item_t it;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            it.req_type = plan[i].kind == ROW_START ? scfre_pkg::REQ_START
                                                    : scfre_pkg::REQ_REPLY;
            it.is_write = plan[i].wr;
            it.reg_address = plan[i].addr;
            it.write_data = plan[i].wd;
            {it.reply_byte0, it.reply_byte1, it.reply_byte2} =
                plan[i].kind == ROW_ECHO ? eng_frame ^ plan[i].bytes : plan[i].bytes;
            if (plan[i].kind == ROW_CFG)
                write_max_resends(plan[i].wd[3:0]);
            else
                send_word(it, plan[i].typed, plan[i].want);
        end

        run_random(scfre_pkg::RESENDS_INIT, PHASE_WORDS, 1'b0, 1'b0, 1'b0);
        run_random(4'd0, PHASE_WORDS, 1'b0, 1'b1, 1'b0);
        run_random(4'd15, PHASE_WORDS, 1'b0, 1'b0, 1'b1);
        run_random(4'd1, PHASE_WORDS, 1'b0, 1'b0, 1'b0);
        run_random(4'($urandom_range(2, 14)), PHASE_WORDS, 1'b1, 1'b0, 1'b0);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("** spi_crc_frame_retry_engine_unit: PASSED **");
        else
            $display("** spi_crc_frame_retry_engine_unit: FAILED **");
        $finish;
    end

endmodule

// ----- sim.f -----
src/scfre_pkg.sv
src/scfre_step.sv
src/spi_crc_frame_retry_engine_unit.sv
src/scfre_checker.sv
test/spi_crc_frame_retry_engine_unit_test.sv
